/* rtl/core/xs1024_pkg.sv */
// Package: shared constants, types and helper functions of the xorshift1024* generator.
package xs1024_pkg;

  localparam int unsigned STATE_WORDS = 16;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned PTR_W       = $clog2(STATE_WORDS);
  localparam int unsigned BIT_W       = $clog2(WORD_W);
  localparam int unsigned JUMP_STEPS  = STATE_WORDS * WORD_W;
  localparam int unsigned CNT_W       = $clog2(JUMP_STEPS);
  localparam int unsigned FRAC_W      = 52;
  localparam int unsigned SEED_W      = 32;
  localparam int unsigned MODE_W      = 2;

  localparam logic [MODE_W-1:0] MODE_DRAW = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_JUMP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;

  localparam logic [WORD_W-1:0] MULT_STAR = 64'd1181783497276652981;
  localparam logic [WORD_W-1:0] PI_BITS   = 64'h400921fb54442d18;
  localparam logic [10:0]       EXP_BIAS  = 11'd1023;

  localparam logic [WORD_W-1:0] JUMP_POLY [STATE_WORDS] = '{
    64'h84242f96eca9c41d, 64'ha3c65b8776f96855, 64'h5b34a39f070b5837,
    64'h4489affce4f31a1e, 64'h2ffeeb0a48316f40, 64'hdc2d9891fe68c022,
    64'h3659132bb12fea70, 64'haac17d8efa43cab8, 64'hc4cb815590989b13,
    64'h5ee975283d71c93b, 64'h691548c86c1bd540, 64'h7910c41d10a1e6a5,
    64'h0b5fc64563b3e2a8, 64'h047f7684e9fc949d, 64'hb99181f2d8f685ca,
    64'h284600e3f30e38c3
  };

  typedef struct packed {
    logic shift;
    logic acc_clr;
    logic acc_xor;
    logic acc_load;
  } cell_ctl_t;

  function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] t;
    t = b ^ (b << 31);
    return t ^ a ^ (t >> 11) ^ (a >> 30);
  endfunction

  function automatic logic [WORD_W-1:0] times33(input logic [WORD_W-1:0] x);
    return x + (x << 5);
  endfunction

endpackage

/* rtl/core/xs1024_cell.sv */
// One state cell: a 64-bit state word and its jump accumulator word.
module xs1024_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  xs1024_pkg::cell_ctl_t       ctl_i,
  input  logic [xs1024_pkg::WORD_W-1:0] shift_i,
  output logic [xs1024_pkg::WORD_W-1:0] word_o
);
  import xs1024_pkg::*;

  logic [WORD_W-1:0] word_q, word_d;
  logic [WORD_W-1:0] acc_q, acc_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.acc_load) begin
      word_d = acc_q;
    end else if (ctl_i.shift) begin
      word_d = shift_i;
    end
    acc_d = acc_q;
    if (ctl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctl_i.acc_xor) begin
      acc_d = acc_q ^ word_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign word_o = word_q;

endmodule

/* rtl/core/xs1024_i2d.sv */
// Integer to IEEE double converter, one normalizing shift per cycle; zero gives pi.
module xs1024_i2d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [xs1024_pkg::SEED_W-1:0] seed_i,
  output logic                          done_o,
  output logic [xs1024_pkg::WORD_W-1:0] bits_o
);
  import xs1024_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              sign_q, sign_d;
  logic [SEED_W-1:0] norm_q, norm_d;
  logic [4:0]        expo_q, expo_d;
  logic [WORD_W-1:0] bits_q, bits_d;
  logic [SEED_W-1:0] mag;

  assign mag = seed_i[SEED_W-1] ? (~seed_i + SEED_W'(1)) : seed_i;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sign_d = sign_q;
    norm_d = norm_q;
    expo_d = expo_q;
    bits_d = bits_q;
    if (start_i) begin
      if (seed_i == '0) begin
        bits_d = PI_BITS;
        done_d = 1'b1;
      end else begin
        sign_d = seed_i[SEED_W-1];
        norm_d = mag;
        expo_d = 5'd31;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (norm_q[SEED_W-1]) begin
        bits_d = {sign_q, EXP_BIAS + {6'b0, expo_q}, norm_q[SEED_W-2:0],
                  (FRAC_W - SEED_W + 1)'(0)};
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        norm_d = norm_q << 1;
        expo_d = expo_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
    norm_q <= norm_d;
    expo_q <= expo_d;
    bits_q <= bits_d;
  end

  assign done_o = done_q;
  assign bits_o = bits_q;

endmodule

/* rtl/core/xs1024_scramble.sv */
// Output scrambler: 64x64 mod 2^64 multiply in two registered stages; items not marked as numbers come out as zero.
module xs1024_scramble (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic                          num_i,
  input  logic [xs1024_pkg::WORD_W-1:0] word_i,
  output logic                          valid_o,
  output logic                          num_o,
  output logic [xs1024_pkg::WORD_W-1:0] raw_o
);
  import xs1024_pkg::*;

  localparam int unsigned HW = WORD_W / 2;

  logic              va_q, vb_q;
  logic              numa_q, numb_q;
  logic [WORD_W-1:0] lo_q;
  logic [HW-1:0]     x1_q, x2_q;
  logic [WORD_W-1:0] lo_d, sum, raw_q, raw_d;
  logic [HW-1:0]     x1_d, x2_d, xsum;

  assign lo_d = {{HW{1'b0}}, word_i[HW-1:0]} * {{HW{1'b0}}, MULT_STAR[HW-1:0]};
  assign x1_d = word_i[HW-1:0] * MULT_STAR[WORD_W-1:HW];
  assign x2_d = word_i[WORD_W-1:HW] * MULT_STAR[HW-1:0];

  assign xsum  = x1_q + x2_q;
  assign sum   = lo_q + {xsum, {HW{1'b0}}};
  assign raw_d = numa_q ? sum : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numa_q <= num_i;
      lo_q   <= lo_d;
      x1_q   <= x1_d;
      x2_q   <= x2_d;
      numb_q <= numa_q;
      raw_q  <= raw_d;
    end
  end

  assign valid_o = vb_q;
  assign num_o   = numb_q;
  assign raw_o   = raw_q;

endmodule

/* rtl/core/xorshift1024star_generator.sv */
// Draw: one request per cycle unless the output stalls; result via v1_q and the scrambler multiply stages.
// Seed: normalize, offset to the word pointer, fill, warm-up, jump steps through the cell
// ring, load, completion; jump only: jump steps, load, completion.
// While a seed or jump runs no request is taken. Reset (rst_ni low, async) clears
// the state ring to zero and the word pointer; draws before a seed return zero.
module xorshift1024star_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // [31:0] seed_value
  input  logic [1:0]   s_axis_tuser,  // [1:0] mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,  // [63:0] raw_value, [115:64] fraction, zero pad
  output logic         m_axis_tuser   // [0] is_number
);
  import xs1024_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_PRE  = 3'd2;
  localparam logic [2:0] ST_FILL = 3'd3;
  localparam logic [2:0] ST_WARM = 3'd4;
  localparam logic [2:0] ST_JUMP = 3'd5;
  localparam logic [2:0] ST_JEND = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]        st_q, st_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [PTR_W-1:0]  idx_q, idx_d;
  logic [WORD_W-1:0] cur_q, cur_d;
  logic [WORD_W-1:0] base_q, base_d;
  logic              v1_q, v1_d;
  logic              num1_q, num1_d;

  logic              pipe_en, accept, adv, fill, inject, draw_acc;
  logic              conv_start, conv_done;
  logic [WORD_W-1:0] conv_bits, adv_word;
  logic [WORD_W-1:0] words    [STATE_WORDS];
  logic [WORD_W-1:0] shift_in [STATE_WORDS];
  cell_ctl_t         ctl;
  logic              out_valid, out_num;
  logic [WORD_W-1:0] out_raw;

  assign pipe_en       = !out_valid || m_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE) && pipe_en;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign adv_word      = xs_next(words[0], words[1]);
  assign fill          = (st_q == ST_FILL);

  always_comb begin
    for (int k = 0; k < STATE_WORDS; k++) begin
      if (k == 0) begin
        shift_in[k] = adv ? adv_word : words[1];
      end else if (k == STATE_WORDS - 1) begin
        shift_in[k] = fill ? cur_q : words[0];
      end else begin
        shift_in[k] = words[k+1];
      end
    end
  end

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    base_d      = base_q;
    adv         = 1'b0;
    ctl         = '0;
    conv_start  = 1'b0;
    inject      = 1'b0;
    draw_acc    = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            MODE_DRAW: begin
              draw_acc  = 1'b1;
              adv       = 1'b1;
              ctl.shift = 1'b1;
              ptr_d     = ptr_q + PTR_W'(1);
            end
            MODE_SEED: begin
              conv_start = 1'b1;
              st_d       = ST_CONV;
            end
            MODE_JUMP: begin
              ctl.acc_clr = 1'b1;
              cnt_d       = '0;
              st_d        = ST_JUMP;
            end
            default: begin
              st_d = ST_DONE;
            end
          endcase
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          cur_d  = times33(conv_bits);
          base_d = times33(conv_bits);
          idx_d  = '0;
          st_d   = ST_PRE;
        end
      end
      ST_PRE: begin
        if (idx_q == ptr_q) begin
          cnt_d = '0;
          st_d  = ST_FILL;
        end else begin
          cur_d = times33(cur_q);
          idx_d = idx_q + PTR_W'(1);
        end
      end
      ST_FILL: begin
        ctl.shift = 1'b1;
        idx_d     = idx_q + PTR_W'(1);
        cur_d     = (idx_d == '0) ? base_q : times33(cur_q);
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STATE_WORDS - 1)) begin
          cnt_d = '0;
          st_d  = ST_WARM;
        end
      end
      ST_WARM: begin
        adv       = 1'b1;
        ctl.shift = 1'b1;
        ptr_d     = ptr_q + PTR_W'(1);
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STATE_WORDS - 1)) begin
          ctl.acc_clr = 1'b1;
          cnt_d       = '0;
          st_d        = ST_JUMP;
        end
      end
      ST_JUMP: begin
        adv         = 1'b1;
        ctl.shift   = 1'b1;
        ctl.acc_xor = JUMP_POLY[cnt_q[CNT_W-1:BIT_W]][cnt_q[BIT_W-1:0]];
        ptr_d       = ptr_q + PTR_W'(1);
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(JUMP_STEPS - 1)) begin
          st_d = ST_JEND;
        end
      end
      ST_JEND: begin
        ctl.acc_load = 1'b1;
        st_d         = ST_DONE;
      end
      ST_DONE: begin
        if (pipe_en) begin
          inject = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    v1_d   = v1_q;
    num1_d = num1_q;
    if (pipe_en) begin
      v1_d   = draw_acc || inject;
      num1_d = draw_acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      ptr_q  <= '0;
      idx_q  <= '0;
      v1_q   <= 1'b0;
      num1_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      ptr_q  <= ptr_d;
      idx_q  <= idx_d;
      v1_q   <= v1_d;
      num1_q <= num1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    base_q <= base_d;
  end

  for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
    xs1024_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .shift_i (shift_in[k]),
      .word_o  (words[k])
    );
  end

  xs1024_i2d u_i2d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .seed_i  (s_axis_tdata),
    .done_o  (conv_done),
    .bits_o  (conv_bits)
  );

  xs1024_scramble u_scramble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v1_q),
    .num_i   (num1_q),
    .word_i  (words[0]),
    .valid_o (out_valid),
    .num_o   (out_num),
    .raw_o   (out_raw)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_num;
  assign m_axis_tdata  = {4'b0, out_raw[FRAC_W-1:0], out_raw};

endmodule

/* dv/tb.sv */
// Testbench: xorshift1024* generator checked request by request against a behavioral model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xs1024_pkg::*;

  localparam logic [63:0] SCRAMBLE_MULT   = 64'd1181783497276652981;
  localparam logic [63:0] PI_PATTERN      = 64'h400921fb54442d18;
  localparam logic [63:0] FILL_FACTOR     = 64'd33;
  localparam int          RANDOM_REQUESTS = 1500;
  localparam int          DRAIN_CYCLES    = 20;
  localparam int          DIRECTED_ROWS   = 24;

  localparam logic [63:0] JUMP_TAPS [16] = '{
    64'h84242f96eca9c41d, 64'ha3c65b8776f96855, 64'h5b34a39f070b5837,
    64'h4489affce4f31a1e, 64'h2ffeeb0a48316f40, 64'hdc2d9891fe68c022,
    64'h3659132bb12fea70, 64'haac17d8efa43cab8, 64'hc4cb815590989b13,
    64'h5ee975283d71c93b, 64'h691548c86c1bd540, 64'h7910c41d10a1e6a5,
    64'h0b5fc64563b3e2a8, 64'h047f7684e9fc949d, 64'hb99181f2d8f685ca,
    64'h284600e3f30e38c3
  };

  typedef struct packed {
    logic [63:0] raw;
    logic [51:0] frac;
    logic        is_num;
  } gen_result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] seed;
    logic        typed;
    logic [63:0] raw;
    logic        is_num;
  } directed_row_t;

  // typed rows: zero state before seeding, completions of seed / jump / idle mode
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_DRAW, 32'h0000_0000, 1'b1, 64'd0, 1'b1},
    '{MODE_DRAW, 32'hffff_ffff, 1'b1, 64'd0, 1'b1},
    '{MODE_NOP,  32'h1234_5678, 1'b1, 64'd0, 1'b0},
    '{MODE_JUMP, 32'h0000_0000, 1'b1, 64'd0, 1'b0},
    '{MODE_DRAW, 32'h0000_0000, 1'b1, 64'd0, 1'b1},
    '{MODE_SEED, 32'h0000_0000, 1'b1, 64'd0, 1'b0},
    '{MODE_DRAW, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
    '{MODE_DRAW, 32'hffff_ffff, 1'b0, 64'd0, 1'b0},
    '{MODE_SEED, 32'h8000_0000, 1'b1, 64'd0, 1'b0},
    '{MODE_DRAW, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
    '{MODE_DRAW, 32'ha5a5_a5a5, 1'b0, 64'd0, 1'b0},
    '{MODE_SEED, 32'h7fff_ffff, 1'b1, 64'd0, 1'b0},
    '{MODE_DRAW, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
    '{MODE_SEED, 32'hffff_ffff, 1'b1, 64'd0, 1'b0},
    '{MODE_DRAW, 32'h5a5a_5a5a, 1'b0, 64'd0, 1'b0},
    '{MODE_SEED, 32'h0000_0001, 1'b1, 64'd0, 1'b0},
    '{MODE_DRAW, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
    '{MODE_JUMP, 32'h5a5a_5a5a, 1'b1, 64'd0, 1'b0},
    '{MODE_DRAW, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
    '{MODE_NOP,  32'hffff_ffff, 1'b1, 64'd0, 1'b0},
    '{MODE_DRAW, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
    '{MODE_SEED, 32'h0000_0400, 1'b1, 64'd0, 1'b0},
    '{MODE_DRAW, 32'hffff_ffff, 1'b0, 64'd0, 1'b0},
    '{MODE_DRAW, 32'h0000_0000, 1'b0, 64'd0, 1'b0}
  };

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata  = '0;  // [31:0] seed_value
  logic [1:0]   s_axis_tuser  = '0;  // [1:0] mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;        // [63:0] raw_value, [115:64] fraction, zero pad
  logic         m_axis_tuser;        // [0] is_number

  logic [63:0]  xs_state [16];
  logic [3:0]   xs_ptr;
  gen_result_t  results_due [$];
  int           errors  = 0;
  int           checked = 0;
  int           n_draw  = 0;
  int           n_seed  = 0;
  int           n_jump  = 0;
  int           n_nop   = 0;

  always #5 clk_i = ~clk_i;

  xorshift1024star_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic logic [63:0] xs_advance();
    logic [3:0]  nxt;
    logic [63:0] a;
    logic [63:0] b;
    nxt = xs_ptr + 4'd1;
    a = xs_state[xs_ptr];
    b = xs_state[nxt];
    b = b ^ (b << 31);
    xs_state[nxt] = b ^ a ^ (b >> 11) ^ (a >> 30);
    xs_ptr = nxt;
    return xs_state[nxt] * SCRAMBLE_MULT;
  endfunction

  function automatic void xs_jump();
    logic [63:0] acc [16];
    for (int j = 0; j < 16; j++) acc[j] = '0;
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < 64; k++) begin
        if (JUMP_TAPS[i][k]) begin
          for (int j = 0; j < 16; j++) acc[j] ^= xs_state[4'(j + xs_ptr)];
        end
        void'(xs_advance());
      end
    end
    for (int j = 0; j < 16; j++) xs_state[4'(j + xs_ptr)] = acc[j];
  endfunction

  // exact double encoding of a nonzero 32-bit signed integer
  function automatic logic [63:0] seed_to_double(logic [31:0] seed);
    logic [31:0] mag;
    logic [63:0] wide;
    int          msb;
    mag = seed[31] ? (~seed + 32'd1) : seed;
    msb = 0;
    for (int k = 0; k < 32; k++) begin
      if (mag[k]) msb = k;
    end
    wide = {32'd0, mag} << (52 - msb);
    return {seed[31], 11'(1023 + msb), wide[51:0]};
  endfunction

  function automatic void xs_seed(logic [31:0] seed);
    xs_state[0] = ((seed == '0) ? PI_PATTERN : seed_to_double(seed)) * FILL_FACTOR;
    for (int i = 1; i < 16; i++) xs_state[i] = xs_state[i-1] * FILL_FACTOR;
    for (int i = 0; i < 16; i++) void'(xs_advance());
    xs_jump();
  endfunction

  function automatic gen_result_t xs_predict(logic [1:0] mode, logic [31:0] seed);
    gen_result_t r;
    r = '0;
    case (mode)
      MODE_DRAW: begin
        r.raw    = xs_advance();
        r.frac   = r.raw[51:0];
        r.is_num = 1'b1;
      end
      MODE_SEED: xs_seed(seed);
      MODE_JUMP: xs_jump();
      default: ;
    endcase
    return r;
  endfunction

  function automatic int idle_length(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_request(logic [1:0] mode, logic [31:0] seed, bit steady,
                              bit typed, gen_result_t typed_res);
    int          gap;
    gen_result_t res;
    gap = idle_length(steady);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seed;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    res = xs_predict(mode, seed);
    results_due.push_back(typed ? typed_res : res);
    case (mode)
      MODE_DRAW: n_draw++;
      MODE_SEED: n_seed++;
      MODE_JUMP: n_jump++;
      default:   n_nop++;
    endcase
  endtask

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  initial begin : stimulus
    gen_result_t typed_res;
    logic [1:0]  mode;
    logic [31:0] seed;
    int          r;
    for (int i = 0; i < 16; i++) xs_state[i] = '0;
    xs_ptr = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      typed_res.raw    = directed_rows[i].raw;
      typed_res.frac   = directed_rows[i].raw[51:0];
      typed_res.is_num = directed_rows[i].is_num;
      send_request(directed_rows[i].mode, directed_rows[i].seed, 1'b0,
                   directed_rows[i].typed, typed_res);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      r = $urandom_range(0, 999);
      if (r < 960)      mode = MODE_DRAW;
      else if (r < 975) mode = MODE_SEED;
      else if (r < 988) mode = MODE_JUMP;
      else              mode = MODE_NOP;
      case ($urandom_range(0, 31))
        0:       seed = 32'h0000_0000;
        1:       seed = 32'h8000_0000;
        2:       seed = 32'h7fff_ffff;
        3:       seed = 32'hffff_ffff;
        4:       seed = 32'h0000_0001;
        default: seed = $urandom;
      endcase
      send_request(mode, seed, ((n / 100) % 5) == 4, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d draws, %0d seeds, %0d jumps and %0d idle-mode requests",
             n_draw, n_seed, n_jump, n_nop);
    $display("%0d results compared, %0d mismatches", checked, errors);
    if (errors == 0 && results_due.size() == 0) begin
      $display("[xorshift1024star_generator] OK");
    end else begin
      $display("[xorshift1024star_generator] ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int len;
    @(posedge clk_i);
    forever begin
      len = ($urandom_range(0, 7) == 0) ? 0 : idle_length(1'b0);
      if (len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (len) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    gen_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unrequested result raw_value", 64'd0, m_axis_tdata[63:0]);
      end else begin
        want = results_due.pop_front();
        checked++;
        if (m_axis_tdata[63:0] !== want.raw)
          report_mismatch("raw_value", want.raw, m_axis_tdata[63:0]);
        if (m_axis_tdata[115:64] !== want.frac)
          report_mismatch("fraction", 64'(want.frac), 64'(m_axis_tdata[115:64]));
        if (m_axis_tuser !== want.is_num)
          report_mismatch("is_number", 64'(want.is_num), 64'(m_axis_tuser));
      end
    end
  end

  initial begin : watchdog
    #10ms;
    $display("Timeout with %0d results still pending", results_due.size());
    $display("[xorshift1024star_generator] ERROR");
    $finish;
  end

endmodule
